// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON unicode-escape to UTF-8 decoder.
package jsu_pkg;

    localparam int MAX_BYTES   = 6;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [MAX_BYTES-1:0][7:0] t_bytes;

    // One classified input item: the bytes it produces, oldest in slot 0.
    typedef struct packed {
        t_bytes     bytes;
        logic [2:0] cnt;
        logic       last;
    } t_bundle;

endpackage

// ===== rtl/jsu_front.sv =====
// Front end: escape phase tracking and per-item output byte assembly.
module jsu_front
    import jsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    [7:0] i_char_in,
    input  logic    i_last_in,
    input  logic    i_q_full,
    output logic    o_q_push,
    output t_bundle o_q_data
);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    typedef enum logic [5:0] {
        PH_PLAIN  = 6'b000001,
        PH_BSLASH = 6'b000010,
        PH_U      = 6'b000100,
        PH_D1     = 6'b001000,
        PH_D2     = 6'b010000,
        PH_D3     = 6'b100000
    } t_phase;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [2:0] ph_len(input t_phase p);
        logic [2:0] n;
        unique case (p)
            PH_BSLASH: n = 3'd1;
            PH_U:      n = 3'd2;
            PH_D1:     n = 3'd3;
            PH_D2:     n = 3'd4;
            PH_D3:     n = 3'd5;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    t_phase     r_phase, n_phase, ph_mid;
    logic [7:0] r_dig [3];
    logic [7:0] n_dig [3];
    logic       accept;
    logic       brk, do_plain, store, do_utf8;
    logic [1:0] store_idx;
    logic [15:0] cp;
    logic [7:0] mid [4];
    logic [2:0] mid_n, a_n, s_n, total;
    logic [7:0] lit_old [8];
    logic [7:0] lit_new [8];
    t_bytes     bytes;

    assign accept = i_push && !i_q_full;

    assign cp = {hex_val(r_dig[0]), hex_val(r_dig[1]), hex_val(r_dig[2]), hex_val(i_char_in)};

    always_comb begin
        brk       = 1'b0;
        do_plain  = 1'b0;
        store     = 1'b0;
        do_utf8   = 1'b0;
        store_idx = 2'd0;
        ph_mid    = PH_PLAIN;
        mid[0]    = i_char_in;
        mid[1]    = 8'h00;
        mid[2]    = 8'h00;
        mid[3]    = 8'h00;
        mid_n     = 3'd0;
        unique case (r_phase)
            PH_BSLASH: begin
                if (i_char_in == CH_U) begin
                    ph_mid = PH_U;
                end else if (i_char_in == CH_QUOTE || i_char_in == CH_BSLASH ||
                             i_char_in == CH_SLASH) begin
                    mid_n = 3'd1;
                end else begin
                    brk      = 1'b1;
                    do_plain = 1'b1;
                end
            end
            PH_U, PH_D1, PH_D2: begin
                if (is_hex(i_char_in)) begin
                    store = 1'b1;
                    if (r_phase == PH_U) begin
                        store_idx = 2'd0;
                        ph_mid    = PH_D1;
                    end else if (r_phase == PH_D1) begin
                        store_idx = 2'd1;
                        ph_mid    = PH_D2;
                    end else begin
                        store_idx = 2'd2;
                        ph_mid    = PH_D3;
                    end
                end else begin
                    brk      = 1'b1;
                    do_plain = 1'b1;
                end
            end
            PH_D3: begin
                if (is_hex(i_char_in)) begin
                    do_utf8 = 1'b1;
                end else begin
                    brk      = 1'b1;
                    do_plain = 1'b1;
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        if (do_plain) begin
            if (i_char_in == CH_BSLASH) begin
                ph_mid = PH_BSLASH;
            end else begin
                mid_n = 3'd1;
            end
        end

        if (do_utf8) begin
            if (cp < 16'h0080) begin
                mid[0] = cp[7:0];
                mid_n  = 3'd1;
            end else if (cp < 16'h0800) begin
                mid[0] = 8'hC0 | {3'b000, cp[10:6]};
                mid[1] = 8'h80 | {2'b00, cp[5:0]};
                mid_n  = 3'd2;
            end else begin
                mid[0] = 8'hE0 | {4'h0, cp[15:12]};
                mid[1] = 8'h80 | {2'b00, cp[11:6]};
                mid[2] = 8'h80 | {2'b00, cp[5:0]};
                mid_n  = 3'd3;
            end
        end
    end

    always_comb begin
        n_dig[0] = r_dig[0];
        n_dig[1] = r_dig[1];
        n_dig[2] = r_dig[2];
        if (store) begin
            n_dig[store_idx] = i_char_in;
        end
    end

    always_comb begin
        lit_old[0] = CH_BSLASH;
        lit_old[1] = CH_U;
        lit_old[2] = r_dig[0];
        lit_old[3] = r_dig[1];
        lit_old[4] = r_dig[2];
        lit_old[5] = 8'h00;
        lit_old[6] = 8'h00;
        lit_old[7] = 8'h00;
        lit_new[0] = CH_BSLASH;
        lit_new[1] = CH_U;
        lit_new[2] = n_dig[0];
        lit_new[3] = n_dig[1];
        lit_new[4] = n_dig[2];
        lit_new[5] = 8'h00;
        lit_new[6] = 8'h00;
        lit_new[7] = 8'h00;
    end

    // Output order: broken-sequence literals, then the item's own bytes,
    // then the end-of-string flush of the new phase.
    assign a_n   = brk ? ph_len(r_phase) : 3'd0;
    assign s_n   = i_last_in ? ph_len(ph_mid) : 3'd0;
    assign total = 3'(a_n + mid_n + s_n);

    always_comb begin
        logic [2:0] kk;
        logic [2:0] km;
        logic [2:0] ks;
        for (int k = 0; k < MAX_BYTES; k++) begin
            kk = 3'(k);
            km = 3'(kk - a_n);
            ks = 3'(km - mid_n);
            if (kk < a_n) begin
                bytes[k] = lit_old[kk];
            end else if (km < mid_n) begin
                bytes[k] = mid[km[1:0]];
            end else begin
                bytes[k] = lit_new[ks];
            end
        end
    end

    assign n_phase = i_last_in ? PH_PLAIN : ph_mid;

    assign o_q_push       = accept && (total != 3'd0);
    assign o_q_data.bytes = bytes;
    assign o_q_data.cnt   = total;
    assign o_q_data.last  = i_last_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_dig[store_idx] <= i_char_in;
        end
    end

endmodule

// ===== rtl/jsu_queue.sv =====
// Short FIFO of classified items between front and back end.
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_avail,
    output t_bundle o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: serializes each classified item into single output bytes.
module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_avail,
    input  t_bundle    i_q_data,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_byte,
    output logic       o_last
);

    t_bytes     r_bytes;
    logic [2:0] r_cnt;
    logic       r_last;
    logic       take, load;

    assign take    = i_pop && (r_cnt != 3'd0);
    assign load    = i_q_avail && ((r_cnt == 3'd0) || (take && r_cnt == 3'd1));
    assign o_q_pop = load;
    assign o_empty = (r_cnt == 3'd0);
    assign o_byte  = r_bytes[0];
    assign o_last  = r_last && (r_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (load) begin
            r_cnt <= i_q_data.cnt;
        end else if (take) begin
            r_cnt <= 3'(r_cnt - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= i_q_data.bytes;
            r_last  <= i_q_data.last;
        end else if (take) begin
            r_bytes <= {8'h00, r_bytes[MAX_BYTES-1:1]};
        end
    end

endmodule

// ===== rtl/json_unicode_escape_to_utf8_top.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
//
//   channel   direction  handshake            payload
//   input     in         push / full          i_char_in[7:0], i_last_in
//   result    out        empty / pop          o_byte_out[7:0], o_last_out
//
// One input byte is accepted per cycle while the item queue has room.
// Each input byte yields 0 to 6 output bytes; while pop is held the back
// end sends one per cycle; the output byte count sets the sustained rate.
// With the back end idle, an accepted item is written to the queue and
// then loaded into the back end, which drives its first byte to the ports.
// Synchronous active-low reset empties the queue and returns to plain text.
// Input and output stall independently; the queue holds DEPTH items.
module json_unicode_escape_to_utf8_top
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_in,
    input  logic       i_last_in,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_byte_out,
    output logic       o_last_out
);

    logic    f_push, q_full, q_avail, q_pop;
    t_bundle f_data, q_data;

    assign full = q_full;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_char_in (i_char_in),
        .i_last_in (i_last_in),
        .i_q_full  (q_full),
        .o_q_push  (f_push),
        .o_q_data  (f_data)
    );

    jsu_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_data),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_data  (q_data)
    );

    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_avail (q_avail),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_byte    (o_byte_out),
        .o_last    (o_last_out)
    );

endmodule

// ===== rtl/jsu_checker.sv =====
// Port-level assertions for the unescaper, bound to the top level.
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       i_last_in,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_byte_out,
    input logic       o_last_out
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_full_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("queue full while no result is offered");

    a_last_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_last_in && empty) |-> ##2 !empty)
        else $error("final item did not reach the result ports");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_byte_out) && $stable(o_last_out)))
        else $error("stalled item changed");

endmodule

bind json_unicode_escape_to_utf8_top jsu_checker u_jsu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .i_last_in  (i_last_in),
    .empty      (empty),
    .pop        (pop),
    .o_byte_out (o_byte_out),
    .o_last_out (o_last_out)
);

// ===== tb/json_unicode_escape_to_utf8_top_tb.sv =====
// Self-checking testbench for the JSON unicode-escape to UTF-8 decoder.
module json_unicode_escape_to_utf8_top_tb;
    import jsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 60;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    typedef enum logic [2:0] {
        PH_TEXT = 3'd0,
        PH_BSL  = 3'd1,
        PH_U    = 3'd2,
        PH_D1   = 3'd3,
        PH_D2   = 3'd4,
        PH_D3   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_out_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_char_in;
    logic       i_last_in;
    logic       empty;
    logic       pop;
    logic [7:0] o_byte_out;
    logic       o_last_out;

    t_phase     phase;
    logic [7:0] digit_chars [3];
    t_out_byte  utf8_expected [$];
    logic [7:0] step_bytes [$];

    int  cycle_count;
    int  items_sent;
    int  bytes_checked;
    int  errors;
    int  full_stalls;
    int  burst_left;
    bit  pace_on;
    bit  hold_req;

    json_unicode_escape_to_utf8_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_char_in  (i_char_in),
        .i_last_in  (i_last_in),
        .empty      (empty),
        .pop        (pop),
        .o_byte_out (o_byte_out),
        .o_last_out (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- decoder prediction ----------------

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        if (step_bytes.size() < MAX_BYTES) step_bytes.push_back(b);
    endfunction

    function automatic void flush_sequence();
        if (phase >= PH_BSL && phase <= PH_D3) emit_byte(CH_BSLASH);
        if (phase >= PH_U && phase <= PH_D3) emit_byte(CH_U);
        if (phase >= PH_D1 && phase <= PH_D3) begin
            for (int i = 0; i < int'(phase) - 2; i++) emit_byte(digit_chars[i]);
        end
        phase = PH_TEXT;
    endfunction

    function automatic void text_byte(input logic [7:0] c);
        if (c == CH_BSLASH) phase = PH_BSL;
        else emit_byte(c);
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic is_last);
        int          hv;
        logic [15:0] cp;
        step_bytes.delete();
        case (phase)
            PH_BSL: begin
                if (c == CH_U) begin
                    phase = PH_U;
                end else if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
                    emit_byte(c);
                    phase = PH_TEXT;
                end else begin
                    flush_sequence();
                    text_byte(c);
                end
            end
            PH_U, PH_D1, PH_D2, PH_D3: begin
                hv = digit_value(c);
                if (hv < 0) begin
                    flush_sequence();
                    text_byte(c);
                end else if (phase != PH_D3) begin
                    digit_chars[int'(phase) - 2] = c;
                    phase = t_phase'(phase + 3'd1);
                end else begin
                    cp = {4'(digit_value(digit_chars[0])), 4'(digit_value(digit_chars[1])),
                          4'(digit_value(digit_chars[2])), 4'(hv)};
                    if (cp < 16'h0080) begin
                        emit_byte(cp[7:0]);
                    end else if (cp < 16'h0800) begin
                        emit_byte(8'hC0 | 8'(cp >> 6));
                        emit_byte(8'h80 | {2'b00, cp[5:0]});
                    end else begin
                        emit_byte(8'hE0 | 8'(cp >> 12));
                        emit_byte(8'h80 | {2'b00, cp[11:6]});
                        emit_byte(8'h80 | {2'b00, cp[5:0]});
                    end
                    phase = PH_TEXT;
                end
            end
            default: begin
                phase = PH_TEXT;
                text_byte(c);
            end
        endcase
        if (is_last) flush_sequence();
        foreach (step_bytes[i])
            utf8_expected.push_back('{data: step_bytes[i],
                                      is_last: is_last && i == step_bytes.size() - 1});
    endfunction

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        t_out_byte want;
        if (i_rst_n && pop && !empty) begin
            bytes_checked++;
            if (utf8_expected.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("ERROR: unexpected output byte %02h last %0b",
                             o_byte_out, o_last_out);
            end else begin
                want = utf8_expected.pop_front();
                if (o_byte_out !== want.data || o_last_out !== want.is_last) begin
                    errors++;
                    if (errors <= SHOWN_ERRORS)
                        $display("ERROR: byte %0d expected %02h/%0b got %02h/%0b",
                                 bytes_checked, want.data, want.is_last,
                                 o_byte_out, o_last_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, utf8_expected.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- output side ----------------

    initial begin
        int rx_mode;
        int rx_left;
        pop     = 1'b0;
        rx_mode = 0;
        rx_left = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_mode)
                0:       pop = 1'b1;
                1:       pop = 1'($urandom_range(0, 1));
                2:       pop = ($urandom_range(0, 3) == 0);
                default: pop = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ---------------- input side ----------------

    task automatic send_item(input logic [7:0] c, input logic is_last);
        int gap;
        if (pace_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    push = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
        end
        push      = 1'b1;
        i_char_in = c;
        i_last_in = is_last;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        decode_byte(c, is_last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_seq(input logic [7:0] seq [$], input logic end_str);
        foreach (seq[i]) send_item(seq[i], end_str && i == seq.size() - 1);
    endtask

    task automatic send_text(input string s, input logic end_str);
        logic [7:0] seq [$];
        for (int i = 0; i < s.len(); i++) seq.push_back(s[i]);
        send_seq(seq, end_str);
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (utf8_expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic upper;
        upper = 1'($urandom_range(0, 1));
        if (v < 4'd10) return 8'("0") + 8'(v);
        return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [15:0] random_cp();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            default: return 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
    endfunction

    function automatic void add_escape(ref logic [7:0] seq [$], input logic [15:0] cp);
        seq.push_back(CH_BSLASH);
        seq.push_back(CH_U);
        for (int i = 3; i >= 0; i--) seq.push_back(hex_char(cp[i*4 +: 4]));
    endfunction

    // One random string fragment: plain noise, escapes, short escapes, or a broken escape.
    task automatic send_fragment(input logic end_str);
        logic [7:0] seq [$];
        int         n;
        case ($urandom_range(0, 9))
            0, 1, 2: seq.push_back(8'($urandom_range(0, 255)));
            3, 4, 5, 6: add_escape(seq, random_cp());
            7: begin
                seq.push_back(CH_BSLASH);
                case ($urandom_range(0, 2))
                    0:       seq.push_back(CH_QUOTE);
                    1:       seq.push_back(CH_BSLASH);
                    default: seq.push_back(CH_SLASH);
                endcase
            end
            default: begin
                n = $urandom_range(0, 4);
                seq.push_back(CH_BSLASH);
                if (n >= 1) seq.push_back(CH_U);
                for (int i = 1; i < n; i++) seq.push_back(hex_char(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 3) != 0) seq.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        send_seq(seq, end_str);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        send_text("\\u0000", 1'b1);
        send_text("\\u07fF", 1'b1);
        send_text("\\uFFFF", 1'b1);
        send_text("\\\"", 1'b1);
        send_text("\\u1z", 1'b1);
        send_text("\\", 1'b1);
        wait_drained();
    endtask

    task automatic test_random();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
            send_fragment($urandom_range(0, 7) == 0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        pace_on  = 1'b0;
        hold_req = 1'b1;
        repeat (15) send_fragment($urandom_range(0, 5) == 0);
        send_item(CH_QUOTE, 1'b1);
        pace_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_char_in     = 8'h00;
        i_last_in     = 1'b0;
        phase         = PH_TEXT;
        digit_chars   = '{default: 8'h00};
        cycle_count   = 0;
        items_sent    = 0;
        bytes_checked = 0;
        errors        = 0;
        full_stalls   = 0;
        burst_left    = 0;
        pace_on       = 1'b1;
        hold_req      = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random();
        test_backpressure();
        test_random();

        $display("covered: directed escapes, %0d input items in all, %0d output bytes checked",
                 items_sent, bytes_checked);
        $display("input stalled on full for %0d cycles, %0d errors", full_stalls, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_unicode_escape_to_utf8_top.sv
rtl/jsu_checker.sv
tb/json_unicode_escape_to_utf8_top_tb.sv
